/* src/fwsa_pkg.sv */
package fwsa_pkg;

  // CORDIC depth; the angle table covers at most MAX_ITER steps
  localparam int ANGLE_ITERATIONS = 16;
  localparam int MAX_ITER         = 24;
  localparam int ITER_N = (ANGLE_ITERATIONS > MAX_ITER) ? MAX_ITER : ANGLE_ITERATIONS;
  localparam int IDX_W  = 5;

  // Datapath widths
  localparam int PROD_W      = 29;  // 12u x 16s products and 2000 * vx
  localparam int DEN_W       = 30;  // 2000 * vx -/+ width * wz
  localparam int CW          = 56;  // prescaled CORDIC x / y
  localparam int ZW          = 32;  // angle accumulator, 0.01 deg Q16
  localparam int PRESCALE_SH = 24;
  localparam int ANG_W       = 15;

  localparam logic signed [ANG_W-1:0] ANGLE_LIMIT   = 15'sd9000;
  localparam logic [11:0]             WHEELBASE_RST = 12'd1310;
  localparam logic [11:0]             TRACK_RST     = 12'd700;
  localparam logic signed [PROD_W-1:0] VX_GAIN      = 29'sd2000;

  // Transaction kinds carried on in_tuser
  localparam logic OP_WIDTH = 1'b0;
  localparam logic OP_CMD   = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic             width_upd;  // store averaged track width
    logic             cmd_load;   // capture vx and wz
    logic             mult;       // form the three products
    logic             den;        // form both denominators
    logic             lane_load;  // prepare both CORDIC lanes
    logic             iter;       // one CORDIC rotation
    logic [IDX_W-1:0] idx;        // rotation index
    logic             finish;     // round and load the output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_busy;  // output register holds a result that is not taken
  } dp_sts_t;

  // atan(2^-i) in degrees * 100 * 65536, rounded
  function automatic logic signed [ZW-1:0] atan_entry(input logic [IDX_W-1:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:    v = 32'sd294912000;
      5'd1:    v = 32'sd174096719;
      5'd2:    v = 32'sd91987925;
      5'd3:    v = 32'sd46694507;
      5'd4:    v = 32'sd23437865;
      5'd5:    v = 32'sd11730358;
      5'd6:    v = 32'sd5866610;
      5'd7:    v = 32'sd2933484;
      5'd8:    v = 32'sd1466764;
      5'd9:    v = 32'sd733385;
      5'd10:   v = 32'sd366693;
      5'd11:   v = 32'sd183346;
      5'd12:   v = 32'sd91673;
      5'd13:   v = 32'sd45837;
      5'd14:   v = 32'sd22918;
      5'd15:   v = 32'sd11459;
      5'd16:   v = 32'sd5730;
      5'd17:   v = 32'sd2865;
      5'd18:   v = 32'sd1432;
      5'd19:   v = 32'sd716;
      5'd20:   v = 32'sd358;
      5'd21:   v = 32'sd179;
      5'd22:   v = 32'sd90;
      5'd23:   v = 32'sd45;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* src/four_wheel_steering_angles_top.sv */
// Steering angles for a four-wheel-steered vehicle with variable track width.
// Each input transaction carries a kind in in_tuser. A width transaction
// (in_tuser = 0) stores the floor of the mean of two encoder widths as the
// track width and produces nothing. A command transaction
// (in_tuser = 1) carries forward speed vx (mm/s) and yaw rate wz (mrad/s)
// and produces one result: left and right front angles, the negated rear
// angles, all in 0.01 degree within -9000..9000, plus vx and wz echoed.
// Each front angle is the angle of (2000*vx -/+ width*wz, wheelbase*wz),
// found by a shared-step CORDIC vectoring unit with two lanes (left, right)
// that rotate side by side, one step per cycle, ANGLE_ITERATIONS steps.
// Zero yaw rate or zero wheelbase gives 0; a zero denominator gives +-9000
// with the sign of the numerator. A command runs in steps: accept,
// multiply, form denominators, load the lanes, the rotation steps, and
// round into the output register. The output register decouples the
// sides, so the next transaction is accepted while a result waits; only
// a second finished result waits for the first to go. The wheelbase
// register (reset 1310 mm) is written through cfg_wen and cfg_wdata;
// write it only while no command is in flight. Track width resets to
// 700 mm.
module four_wheel_steering_angles_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wen,
  input  logic [11:0] cfg_wdata,    // wheelbase_mm
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,     // op: 0 width update, 1 velocity command
  // [15:0] linear_velocity, [31:16] angular_velocity,
  // [43:32] width_reading_a, [55:44] width_reading_b
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [14:0] left_front_angle, [29:15] right_front_angle,
  // [44:30] left_back_angle, [59:45] right_back_angle,
  // [75:60] echo_linear, [91:76] echo_angular, [95:92] zero
  output logic [95:0] out_tdata
);
  import fwsa_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequence each transaction: accept, and for commands multiply, rotate, deliver
  fwsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Hold geometry, run both CORDIC lanes, own the output register
  fwsa_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* src/fwsa_ctrl.sv */
module fwsa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_tuser,
  output fwsa_pkg::dp_cmd_t cmd,
  input  fwsa_pkg::dp_sts_t sts
);
  import fwsa_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULT,
    ST_DEN,
    ST_LOAD,
    ST_ITER,
    ST_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_tuser == OP_CMD) state_nxt = ST_MULT;
      end
      ST_MULT: state_nxt = ST_DEN;
      ST_DEN:  state_nxt = ST_LOAD;
      ST_LOAD: begin
        state_nxt = ST_ITER;
        idx_nxt   = '0;
      end
      ST_ITER: begin
        if (idx_r == IDX_W'(ITER_N - 1)) state_nxt = ST_DONE;
        else idx_nxt = idx_r + 1'b1;
      end
      ST_DONE: begin
        if (!sts.out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.width_upd = accept && (in_tuser == OP_WIDTH);
    cmd.cmd_load  = accept && (in_tuser == OP_CMD);
    cmd.mult      = (state_r == ST_MULT);
    cmd.den       = (state_r == ST_DEN);
    cmd.lane_load = (state_r == ST_LOAD);
    cmd.iter      = (state_r == ST_ITER);
    cmd.idx       = idx_r;
    cmd.finish    = (state_r == ST_DONE) && !sts.out_busy;
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ITER |-> idx_r <= IDX_W'(ITER_N - 1))
    else $error("rotation index beyond last step");

  a_hold_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && sts.out_busy |=> state_r == ST_DONE)
    else $error("result dropped while output register busy");

  a_cmd_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tuser == OP_CMD |=> state_r == ST_MULT)
    else $error("command transaction did not start computation");

  a_width_stay: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tuser == OP_WIDTH |=> state_r == ST_IDLE)
    else $error("width transaction left idle");

endmodule

/* src/fwsa_dp.sv */
module fwsa_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wen,
  input  logic [11:0]       cfg_wdata,
  input  logic [55:0]       in_tdata,
  input  fwsa_pkg::dp_cmd_t cmd,
  output fwsa_pkg::dp_sts_t sts,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [95:0]       out_tdata
);
  import fwsa_pkg::*;

  logic [11:0]              wheelbase_r;
  logic [11:0]              track_r;
  logic signed [15:0]       vx_r, wz_r;
  logic                     wz_zero_r;
  logic signed [PROD_W-1:0] num_r, twz_r, vxg_r;
  logic signed [DEN_W-1:0]  den_r [2];
  logic signed [CW-1:0]     x_r [2], y_r [2];
  logic signed [ZW-1:0]     z_r [2];
  logic                     spec_r [2];
  logic signed [ANG_W-1:0]  spec_val_r [2];
  logic                     out_valid_r;
  logic [95:0]              out_data_r;

  logic signed [CW-1:0]     x_ld [2], y_ld [2], x_it [2], y_it [2];
  logic signed [ZW-1:0]     z_it [2];
  logic                     spec_ld [2];
  logic signed [ANG_W-1:0]  spec_val_ld [2];
  logic signed [ANG_W-1:0]  ang [2];
  logic [12:0]              width_sum;

  assign width_sum = {1'b0, in_tdata[43:32]} + {1'b0, in_tdata[55:44]};

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      logic                 neg;
      logic signed [CW-1:0] xe, ye, xs, ys;
      logic [ZW-1:0]        mag;
      logic [16:0]          rnd;
      logic [13:0]          sat;
      // lane load: fold left half plane into right, then prescale
      neg            = den_r[k][DEN_W-1];
      xe             = CW'(den_r[k]);
      ye             = CW'(num_r);
      x_ld[k]        = (neg ? -xe : xe) <<< PRESCALE_SH;
      y_ld[k]        = (neg ? -ye : ye) <<< PRESCALE_SH;
      spec_ld[k]     = wz_zero_r || (num_r == '0) || (den_r[k] == '0);
      if (wz_zero_r || num_r == '0) spec_val_ld[k] = '0;
      else if (num_r[PROD_W-1])     spec_val_ld[k] = -ANGLE_LIMIT;
      else                          spec_val_ld[k] = ANGLE_LIMIT;
      // one rotation toward y = 0
      xs = x_r[k] >>> cmd.idx;
      ys = y_r[k] >>> cmd.idx;
      if (!y_r[k][CW-1] && y_r[k] != '0) begin
        x_it[k] = x_r[k] + ys;
        y_it[k] = y_r[k] - xs;
        z_it[k] = z_r[k] + atan_entry(cmd.idx);
      end else begin
        x_it[k] = x_r[k] - ys;
        y_it[k] = y_r[k] + xs;
        z_it[k] = z_r[k] - atan_entry(cmd.idx);
      end
      // round half away from zero, saturate to +-90 deg
      mag = z_r[k][ZW-1] ? ZW'(-z_r[k]) : ZW'(z_r[k]);
      rnd = 17'((mag + ZW'(32768)) >> 16);
      sat = (rnd > 17'(ANGLE_LIMIT)) ? 14'(ANGLE_LIMIT) : rnd[13:0];
      if (spec_r[k])          ang[k] = spec_val_r[k];
      else if (z_r[k][ZW-1])  ang[k] = -$signed({1'b0, sat});
      else                    ang[k] = $signed({1'b0, sat});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheelbase_r <= WHEELBASE_RST;
      track_r     <= TRACK_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wen)       wheelbase_r <= cfg_wdata;
      if (cmd.width_upd) track_r     <= width_sum[12:1];
      if (cmd.finish)          out_valid_r <= 1'b1;
      else if (out_tready)     out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cmd_load) begin
      vx_r      <= $signed(in_tdata[15:0]);
      wz_r      <= $signed(in_tdata[31:16]);
      wz_zero_r <= (in_tdata[31:16] == 16'd0);
    end
    if (cmd.mult) begin
      num_r <= $signed({17'd0, wheelbase_r}) * PROD_W'(wz_r);
      twz_r <= $signed({17'd0, track_r}) * PROD_W'(wz_r);
      vxg_r <= PROD_W'(vx_r) * VX_GAIN;
    end
    if (cmd.den) begin
      den_r[0] <= DEN_W'(vxg_r) - DEN_W'(twz_r);
      den_r[1] <= DEN_W'(vxg_r) + DEN_W'(twz_r);
    end
    for (int k = 0; k < 2; k++) begin
      if (cmd.lane_load) begin
        x_r[k]        <= x_ld[k];
        y_r[k]        <= y_ld[k];
        z_r[k]        <= '0;
        spec_r[k]     <= spec_ld[k];
        spec_val_r[k] <= spec_val_ld[k];
      end else if (cmd.iter) begin
        x_r[k] <= x_it[k];
        y_r[k] <= y_it[k];
        z_r[k] <= z_it[k];
      end
    end
    if (cmd.finish) begin
      out_data_r <= {4'd0, wz_r, vx_r, -ang[1], -ang[0], ang[1], ang[0]};
    end
  end

  assign sts.out_busy = out_valid_r && !out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;

endmodule

/* sim/tb_four_wheel_steering_angles_top.sv */
module tb_four_wheel_steering_angles_top;
  import fwsa_pkg::*;

  localparam logic [15:0] VEL_MIN = 16'h8000;
  localparam logic [15:0] VEL_MAX = 16'h7FFF;

  // Quiet cycles before a wheelbase write: covers a width update still in
  // flight plus the full command latency with margin.
  localparam int SETTLE_CYCLES = ITER_N + 12;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PHASE_ITEMS   = 195;
  localparam int PLAN_LEN      = 24;

  // atan(2^-i) in 0.01 degree, Q16
  localparam longint ATAN_Q16 [24] = '{
    294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
    5866610, 2933484, 1466764, 733385, 366693, 183346,
    91673, 45837, 22918, 11459, 5730, 2865,
    1432, 716, 358, 179, 90, 45
  };

  // Result layout, MSB first, matching out_tdata
  typedef struct packed {
    logic [3:0]         pad;
    logic signed [15:0] wz;
    logic signed [15:0] vx;
    logic signed [14:0] rb;
    logic signed [14:0] lb;
    logic signed [14:0] rf;
    logic signed [14:0] lf;
  } steer_result_t;

  typedef enum logic [1:0] {ROW_WIDTH, ROW_CMD, ROW_CFG} row_kind_t;

  // Directed row: a/b are vx/wz for commands, the two widths for width
  // updates, the wheelbase in a for register writes. When typed is set,
  // lf/rf are the front angles read straight off the spec.
  typedef struct packed {
    row_kind_t          kind;
    logic [15:0]        a;
    logic [15:0]        b;
    logic               typed;
    logic signed [14:0] lf;
    logic signed [14:0] rf;
  } plan_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wen;
  logic [11:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic        in_tuser;
  logic [55:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;

  // Shadow of the block's state
  int tb_wheelbase_mm;
  int tb_track_mm;

  steer_result_t pending_angles [$];
  bit            steady;
  int            cycle_count;
  int            error_count;
  int            n_commands;
  int            n_width_updates;
  int            n_cfg_writes;
  int            n_checked;

  plan_row_t plan [PLAN_LEN] = '{
    // after reset: zero yaw rate gives zero angles, speed only echoed
    '{ROW_CMD,   16'd0,    16'd0,      1'b1, 15'sd0, 15'sd0},
    '{ROW_CMD,   VEL_MAX,  16'd0,      1'b1, 15'sd0, 15'sd0},
    '{ROW_CMD,   VEL_MIN,  16'd0,      1'b1, 15'sd0, 15'sd0},
    '{ROW_CMD,   16'd1000, 16'd500,    1'b0, 15'sd0, 15'sd0},
    '{ROW_CMD,   VEL_MIN,  VEL_MIN,    1'b0, 15'sd0, 15'sd0},
    '{ROW_CMD,   VEL_MAX,  VEL_MAX,    1'b0, 15'sd0, 15'sd0},
    // track 700: left, then right denominator hits zero
    '{ROW_CMD,   16'd7,    16'd20,     1'b0, 15'sd0, 15'sd0},
    '{ROW_CMD,   -16'sd7,  16'd20,     1'b0, 15'sd0, 15'sd0},
    '{ROW_WIDTH, 16'd4095, 16'd4095,   1'b0, 15'sd0, 15'sd0},
    '{ROW_CMD,   VEL_MIN,  VEL_MAX,    1'b0, 15'sd0, 15'sd0},
    '{ROW_WIDTH, 16'd4095, 16'd0,      1'b0, 15'sd0, 15'sd0},
    // track 0 and vx 0: both denominators zero, angle takes sign of wz
    '{ROW_WIDTH, 16'd0,    16'd0,      1'b0, 15'sd0, 15'sd0},
    '{ROW_CMD,   16'd0,    16'd5,      1'b1, 15'sd9000, 15'sd9000},
    '{ROW_CMD,   16'd0,    -16'sd5,    1'b1, -15'sd9000, -15'sd9000},
    '{ROW_CMD,   16'd100,  VEL_MIN,    1'b0, 15'sd0, 15'sd0},
    // zero wheelbase: numerator zero, angles zero even with x zero
    '{ROW_CFG,   16'd0,    16'd0,      1'b0, 15'sd0, 15'sd0},
    '{ROW_CMD,   16'd300,  16'd1000,   1'b1, 15'sd0, 15'sd0},
    '{ROW_CMD,   16'd0,    16'd77,     1'b1, 15'sd0, 15'sd0},
    '{ROW_CFG,   16'd4095, 16'd0,      1'b0, 15'sd0, 15'sd0},
    '{ROW_WIDTH, 16'd1234, 16'd567,    1'b0, 15'sd0, 15'sd0},
    '{ROW_CMD,   16'hFFFF, 16'hFFFF,   1'b0, 15'sd0, 15'sd0},
    '{ROW_CMD,   VEL_MAX,  VEL_MIN,    1'b0, 15'sd0, 15'sd0},
    '{ROW_CFG,   16'd1310, 16'd0,      1'b0, 15'sd0, 15'sd0},
    '{ROW_WIDTH, 16'd700,  16'd700,    1'b0, 15'sd0, 15'sd0}
  };

  four_wheel_steering_angles_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Angle of (x, y) by CORDIC vectoring, rounded to 0.01 degree and
  // clamped to +-90 degrees.
  function automatic logic signed [14:0] front_angle(input longint x, input longint y);
    longint z = 0;
    longint xs, ys, r;
    if (y == 0) return 15'sd0;
    // vertical vector: straight +-90 with the sign of the numerator
    if (x == 0) return (y > 0) ? ANGLE_LIMIT : -ANGLE_LIMIT;
    // fold the left half plane onto the right, ratio unchanged
    if (x < 0) begin
      x = -x;
      y = -y;
    end
    x = x <<< PRESCALE_SH;
    y = y <<< PRESCALE_SH;
    for (int i = 0; i < ITER_N; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_Q16[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_Q16[i];
      end
    end
    // round half away from zero, then clamp
    if (z >= 0) r = (z + 32768) >>> 16;
    else        r = -((-z + 32768) >>> 16);
    if (r > 9000)  r = 9000;
    if (r < -9000) r = -9000;
    return r[14:0];
  endfunction

  // Expected result of one velocity command under the current wheelbase
  // and track width.
  function automatic steer_result_t steer_predict(input logic signed [15:0] vx,
                                                  input logic signed [15:0] wz);
    steer_result_t r;
    longint num, lden, rden;
    r    = '0;
    r.vx = vx;
    r.wz = wz;
    if (wz != 0) begin
      num  = longint'(tb_wheelbase_mm) * longint'(wz);
      lden = 2000 * longint'(vx) - longint'(tb_track_mm) * longint'(wz);
      rden = 2000 * longint'(vx) + longint'(tb_track_mm) * longint'(wz);
      r.lf = front_angle(lden, num);
      r.rf = front_angle(rden, num);
    end
    r.lb = -r.lf;
    r.rb = -r.rf;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR cycle %0d result %0d: %s", cycle_count, n_checked, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got)
      report_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
  endtask

  // Offer one transaction, hold it until accepted, then advance the shadow
  // state or queue the expected result.
  task automatic send_item(input logic op, input logic [15:0] vx, input logic [15:0] wz,
                           input logic [11:0] wa, input logic [11:0] wb,
                           input bit typed, input steer_result_t typed_result);
    while (!steady && $urandom_range(99) < 29) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {wb, wa, wz, vx};
    do @(posedge clk); while (!in_tready);
    if (op == OP_CMD) begin
      pending_angles.push_back(typed ? typed_result : steer_predict(vx, wz));
      n_commands++;
    end else begin
      tb_track_mm = (int'(wa) + int'(wb)) >> 1;
      n_width_updates++;
    end
  endtask

  // Drop valid and hold off until every queued result has been taken.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
  endtask

  // Write the wheelbase only once the block has gone quiet.
  task automatic write_wheelbase(input logic [11:0] wb);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= wb;
    @(posedge clk);
    cfg_wen <= 1'b0;
    tb_wheelbase_mm = wb;
    n_cfg_writes++;
  endtask

  // Speeds and yaw rates: extremes, zero, small values near the turning
  // geometry, and full-range noise.
  function automatic logic [15:0] rand_velocity();
    case ($urandom_range(9))
      0:       return $urandom_range(1) ? VEL_MAX : VEL_MIN;
      1:       return 16'd0;
      2, 3:    return 16'($urandom_range(400)) - 16'd200;
      default: return 16'($urandom);
    endcase
  endfunction

  // Accept results when both valid and ready are high at the edge; compare
  // each against the oldest expectation.
  always @(posedge clk) begin
    steer_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = steer_result_t'(out_tdata);
      if (pending_angles.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: %h", out_tdata));
      end else begin
        want = pending_angles.pop_front();
        check_field("left_front_angle",  want.lf, got.lf);
        check_field("right_front_angle", want.rf, got.rf);
        check_field("left_back_angle",   want.lb, got.lb);
        check_field("right_back_angle",  want.rb, got.rb);
        check_field("echo_linear",       want.vx, got.vx);
        check_field("echo_angular",      want.wz, got.wz);
        check_field("pad",               want.pad, got.pad);
      end
      n_checked++;
    end
  end

  // Receiver side: stall about 29 percent of the time, never during a steady phase.
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 29);
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL four_wheel_steering_angles_top");
      $finish;
    end
  end

  initial begin
    steer_result_t typed_result;
    logic [11:0]   phase_wheelbase [6];
    int            roll, j, sv, sw;

    rst_n           = 1'b0;
    cfg_wen         = 1'b0;
    cfg_wdata       = '0;
    in_tvalid       = 1'b0;
    in_tuser        = OP_WIDTH;
    in_tdata        = '0;
    out_tready      = 1'b0;
    steady          = 1'b0;
    cycle_count     = 0;
    error_count     = 0;
    n_commands      = 0;
    n_width_updates = 0;
    n_cfg_writes    = 0;
    n_checked       = 0;
    tb_wheelbase_mm = WHEELBASE_RST;
    tb_track_mm     = TRACK_RST;

    // Wheelbase per random phase: reset value, both extremes, one, random,
    // and a mid value.
    phase_wheelbase = '{12'd1310, 12'd0, 12'd4095, 12'd1, 12'($urandom), 12'd2048};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: walk the plan rows in order.
    for (int k = 0; k < PLAN_LEN; k++) begin
      case (plan[k].kind)
        ROW_CFG: begin
          write_wheelbase(plan[k].a[11:0]);
        end
        ROW_WIDTH: begin
          send_item(OP_WIDTH, 16'($urandom), 16'($urandom), plan[k].a[11:0],
                    plan[k].b[11:0], 1'b0, '0);
        end
        default: begin
          typed_result    = '0;
          typed_result.vx = plan[k].a;
          typed_result.wz = plan[k].b;
          typed_result.lf = plan[k].lf;
          typed_result.rf = plan[k].rf;
          typed_result.lb = -plan[k].lf;
          typed_result.rb = -plan[k].rf;
          send_item(OP_CMD, plan[k].a, plan[k].b, 12'($urandom), 12'($urandom),
                    plan[k].typed, typed_result);
        end
      endcase
    end

    // Random part: one phase per wheelbase setting. Phase 2 runs with no
    // idling on either side; phase 3 pauses midway until all results drain.
    for (int p = 0; p < 6; p++) begin
      write_wheelbase(phase_wheelbase[p]);
      steady <= (p == 2);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 3 && k == PHASE_ITEMS / 2) drain_results();
        roll = $urandom_range(99);
        if (roll < 20) begin
          send_item(OP_WIDTH, 16'($urandom), 16'($urandom), 12'($urandom),
                    ($urandom_range(3) == 0) ? 12'($urandom_range(1500, 400)) : 12'($urandom),
                    1'b0, '0);
        end else if (roll < 26) begin
          // Track 1000 makes a denominator vanish when wz = +-2*vx.
          j  = $urandom_range(16383, 1);
          sv = $urandom_range(1) ? j : -j;
          sw = $urandom_range(1) ? 2 * j : -2 * j;
          send_item(OP_WIDTH, 16'($urandom), 16'($urandom), 12'd1000, 12'd1000, 1'b0, '0);
          send_item(OP_CMD, 16'(sv), 16'(sw), 12'($urandom), 12'($urandom), 1'b0, '0);
        end else begin
          send_item(OP_CMD, rand_velocity(), rand_velocity(), 12'($urandom),
                    12'($urandom), 1'b0, '0);
        end
      end
    end

    // Let the last results drain, then allow the block to settle.
    drain_results();
    steady <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d velocity commands and %0d width updates over %0d wheelbase writes,",
             n_commands, n_width_updates, n_cfg_writes);
    $display("  including zero yaw, zero numerator and vertical-vector cases; %0d results checked.",
             n_checked);
    if (error_count == 0)
      $display("PASS four_wheel_steering_angles_top");
    else
      $display("FAIL four_wheel_steering_angles_top");
    $finish;
  end

endmodule
